>>> src/ctms_pkg.sv
// Package with shared codes, widths and control structs for the swap-move block.
package ctms_pkg;

    localparam int IDX_W  = 3;
    localparam int VAL_W  = 17;
    localparam int DRAW_W = 16;
    localparam int PROB_W = 17;
    localparam int READ_W = 16;

    localparam logic [1:0] OP_LOAD_COUNT = 2'd0;
    localparam logic [1:0] OP_LOAD_PROB  = 2'd1;
    localparam logic [1:0] OP_MOVE       = 2'd2;
    localparam logic [1:0] OP_READ       = 2'd3;

    localparam logic [1:0] ST_CODE_DONE = 2'd0;
    localparam logic [1:0] ST_CODE_ACC  = 2'd1;
    localparam logic [1:0] ST_CODE_REJ  = 2'd2;
    localparam logic [1:0] ST_CODE_SKIP = 2'd3;

    localparam logic [1:0] RD_PAIR_A = 2'd0;  // named cells (ga,ca) and (gb,cb)
    localparam logic [1:0] RD_PAIR_X = 2'd1;  // crossed cells (ga,cb) and (gb,ca)
    localparam logic [1:0] RD_CELL   = 2'd2;  // row/col cell

    localparam logic SIDE_NUM = 1'b0;
    localparam logic SIDE_DEN = 1'b1;

    typedef struct packed {
        logic       latch;
        logic       load_wr;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_a;
        logic       cap_x;
        logic       mul_load;
        logic       mul_step;
        logic       mul_side;
        logic [1:0] mul_k;
        logic       save_num;
        logic       upd_wr;
        logic [1:0] upd_idx;
        logic       out_load;
        logic [1:0] out_status;
        logic       out_use_read;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       cell_ok;
        logic       move_ok;
        logic       zero;
        logic       less;
        logic       full;
        logic       alias_cells;
    } stat_t;

endpackage

>>> src/ctms_datapath.sv
// Datapath: count and probability memories, shift-add multiplier, compare and output register.
module ctms_datapath #(
    parameter int MAX_GROUPS     = 8,
    parameter int MAX_CANDIDATES = 8,
    parameter int COUNT_WIDTH    = 16,
    parameter int PROB_FRAC_BITS = 16,
    parameter int MW             = 17,
    parameter int PW             = 118
) (
    input  logic                         aclk,
    input  ctms_pkg::cmd_t               cmd,
    output ctms_pkg::stat_t              stat,
    input  logic [1:0]                   in_op,
    input  logic [ctms_pkg::IDX_W-1:0]   in_row,
    input  logic [ctms_pkg::IDX_W-1:0]   in_col,
    input  logic [ctms_pkg::VAL_W-1:0]   in_value,
    input  logic [ctms_pkg::IDX_W-1:0]   in_ga,
    input  logic [ctms_pkg::IDX_W-1:0]   in_ca,
    input  logic [ctms_pkg::IDX_W-1:0]   in_gb,
    input  logic [ctms_pkg::IDX_W-1:0]   in_cb,
    input  logic [ctms_pkg::DRAW_W-1:0]  in_draw,
    output logic [1:0]                   out_status,
    output logic [ctms_pkg::READ_W-1:0]  out_read
);
    localparam int CELLS = MAX_GROUPS * MAX_CANDIDATES;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = COUNT_WIDTH;
    localparam int PB    = ctms_pkg::PROB_W;

    logic [1:0]                  op_reg;
    logic [ctms_pkg::IDX_W-1:0]  row_reg, col_reg, ga_reg, ca_reg, gb_reg, cb_reg;
    logic [ctms_pkg::VAL_W-1:0]  value_reg;
    logic [ctms_pkg::DRAW_W-1:0] draw_reg;

    logic [CW-1:0] cnt_mem [CELLS];
    logic [PB-1:0] prob_mem [CELLS];
    logic [CW-1:0] cnt_rd0_reg, cnt_rd1_reg;
    logic [PB-1:0] prob_rd0_reg, prob_rd1_reg;

    logic [CW-1:0] zaa_reg, zbb_reg, zab_reg, zba_reg;
    logic [PB-1:0] paa_reg, pbb_reg, pab_reg, pba_reg;

    logic [PW-1:0] acc_reg, mcand_reg, num_reg;
    logic [MW-1:0] mplier_reg;

    logic [1:0]                 out_status_reg;
    logic [ctms_pkg::READ_W-1:0] out_read_reg;

    function automatic logic in_grid(input logic [2:0] g, input logic [2:0] c);
        return (int'(g) < MAX_GROUPS) && (int'(c) < MAX_CANDIDATES);
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [2:0] g, input logic [2:0] c);
        return AW'(int'(g) * MAX_CANDIDATES + int'(c));
    endfunction

    logic [AW-1:0] a_cell, a_aa, a_bb, a_ab, a_ba;
    assign a_cell = cell_addr(row_reg, col_reg);
    assign a_aa   = cell_addr(ga_reg, ca_reg);
    assign a_bb   = cell_addr(gb_reg, cb_reg);
    assign a_ab   = cell_addr(ga_reg, cb_reg);
    assign a_ba   = cell_addr(gb_reg, ca_reg);

    // Clamped load values.
    logic [48:0]   vext;
    logic [CW-1:0] cnt_load;
    logic [PB-1:0] prob_load;
    always_comb begin
        vext = 49'(value_reg);
        if (vext > 49'((64'd1 << CW) - 64'd1)) begin
            cnt_load = '1;
        end else begin
            cnt_load = CW'(vext);
        end
        if (vext > (49'd1 << PROB_FRAC_BITS)) begin
            prob_load = PB'(49'd1 << PROB_FRAC_BITS);
        end else begin
            prob_load = PB'(vext);
        end
    end

    // Count memory write port: loads and the four move updates.
    logic          cnt_we;
    logic [AW-1:0] cnt_wa;
    logic [CW-1:0] cnt_wd;
    always_comb begin
        cnt_we = 1'b0;
        cnt_wa = a_cell;
        cnt_wd = cnt_load;
        if (cmd.load_wr && op_reg == ctms_pkg::OP_LOAD_COUNT) begin
            cnt_we = 1'b1;
        end else if (cmd.upd_wr) begin
            cnt_we = 1'b1;
            case (cmd.upd_idx)
                2'd0: begin
                    cnt_wa = a_aa;
                    cnt_wd = zaa_reg - CW'(1);
                end
                2'd1: begin
                    cnt_wa = a_bb;
                    cnt_wd = zbb_reg - CW'(1);
                end
                2'd2: begin
                    cnt_wa = a_ab;
                    cnt_wd = zab_reg + CW'(1);
                end
                default: begin
                    cnt_wa = a_ba;
                    cnt_wd = zba_reg + CW'(1);
                end
            endcase
        end
    end

    logic [AW-1:0] ra0, ra1;
    always_comb begin
        case (cmd.rd_sel)
            ctms_pkg::RD_PAIR_A: begin
                ra0 = a_aa;
                ra1 = a_bb;
            end
            ctms_pkg::RD_PAIR_X: begin
                ra0 = a_ab;
                ra1 = a_ba;
            end
            default: begin
                ra0 = a_cell;
                ra1 = a_cell;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cmd.load_wr && op_reg == ctms_pkg::OP_LOAD_PROB) begin
            prob_mem[a_cell] <= prob_load;
        end
        if (cmd.rd_en) begin
            cnt_rd0_reg  <= cnt_mem[ra0];
            cnt_rd1_reg  <= cnt_mem[ra1];
            prob_rd0_reg <= prob_mem[ra0];
            prob_rd1_reg <= prob_mem[ra1];
        end
    end

    // Multiplier operand for each step of the numerator and denominator chains.
    logic [MW-1:0] operand;
    logic [PW-1:0] chain_start;
    always_comb begin
        if (cmd.mul_side == ctms_pkg::SIDE_NUM) begin
            chain_start = PW'(draw_reg);
            case (cmd.mul_k)
                2'd0:    operand = MW'({1'b0, zab_reg} + (CW + 1)'(1));
                2'd1:    operand = MW'({1'b0, zba_reg} + (CW + 1)'(1));
                2'd2:    operand = MW'(paa_reg);
                default: operand = MW'(pbb_reg);
            endcase
        end else begin
            chain_start = PW'(1) << 16;
            case (cmd.mul_k)
                2'd0:    operand = MW'(zaa_reg);
                2'd1:    operand = MW'(zbb_reg);
                2'd2:    operand = MW'(pab_reg);
                default: operand = MW'(pba_reg);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg    <= in_op;
            row_reg   <= in_row;
            col_reg   <= in_col;
            value_reg <= in_value;
            ga_reg    <= in_ga;
            ca_reg    <= in_ca;
            gb_reg    <= in_gb;
            cb_reg    <= in_cb;
            draw_reg  <= in_draw;
        end
        if (cmd.cap_a) begin
            zaa_reg <= cnt_rd0_reg;
            zbb_reg <= cnt_rd1_reg;
            paa_reg <= prob_rd0_reg;
            pbb_reg <= prob_rd1_reg;
        end
        if (cmd.cap_x) begin
            zab_reg <= cnt_rd0_reg;
            zba_reg <= cnt_rd1_reg;
            pab_reg <= prob_rd0_reg;
            pba_reg <= prob_rd1_reg;
        end
        if (cmd.mul_load) begin
            mcand_reg  <= (cmd.mul_k == 2'd0) ? chain_start : acc_reg;
            acc_reg    <= '0;
            mplier_reg <= operand;
        end else if (cmd.mul_step) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
        if (cmd.save_num) begin
            num_reg <= acc_reg;
        end
        if (cmd.out_load) begin
            out_status_reg <= cmd.out_status;
            out_read_reg   <= (cmd.out_use_read && stat.cell_ok) ?
                              ctms_pkg::READ_W'(cnt_rd0_reg) : '0;
        end
    end

    always_comb begin
        stat.op          = op_reg;
        stat.cell_ok     = in_grid(row_reg, col_reg);
        stat.move_ok     = in_grid(ga_reg, ca_reg) && in_grid(gb_reg, cb_reg) &&
                           in_grid(ga_reg, cb_reg) && in_grid(gb_reg, ca_reg);
        stat.zero        = (zaa_reg == '0) || (zbb_reg == '0);
        stat.less        = num_reg < acc_reg;
        stat.full        = (&zab_reg) || (&zba_reg);
        stat.alias_cells = (ga_reg == gb_reg) || (ca_reg == cb_reg);
    end

    assign out_status = out_status_reg;
    assign out_read   = out_read_reg;

endmodule

>>> src/ctms_ctrl.sv
// Controller state machine that sequences loads, reads and the swap-move evaluation.
module ctms_ctrl #(
    parameter int MW = 17
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output ctms_pkg::cmd_t  cmd,
    input  ctms_pkg::stat_t stat
);
    localparam int BW = $clog2(MW + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_RDX  = 4'd2;
    localparam logic [3:0] S_CAPX = 4'd3;
    localparam logic [3:0] S_ZCHK = 4'd4;
    localparam logic [3:0] S_LOAD = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_SAVE = 4'd7;
    localparam logic [3:0] S_CMP  = 4'd8;
    localparam logic [3:0] S_WR   = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [BW-1:0] bit_reg, bit_next;
    logic [1:0]    k_reg, k_next;
    logic          side_reg, side_next;
    logic [1:0]    widx_reg, widx_next;
    logic [1:0]    code_reg, code_next;
    logic          useread_reg, useread_next;
    logic          mvalid_reg, mvalid_next;
    logic          out_free;

    assign out_free = !mvalid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = mvalid_reg;

    always_comb begin
        state_next   = state_reg;
        bit_next     = bit_reg;
        k_next       = k_reg;
        side_next    = side_reg;
        widx_next    = widx_reg;
        code_next    = code_reg;
        useread_next = useread_reg;
        mvalid_next  = mvalid_reg && !m_ready;
        cmd          = '0;
        cmd.mul_side = side_reg;
        cmd.mul_k    = k_reg;
        cmd.upd_idx  = widx_reg;
        cmd.out_status   = code_reg;
        cmd.out_use_read = useread_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                code_next    = ctms_pkg::ST_CODE_DONE;
                useread_next = 1'b0;
                case (stat.op)
                    ctms_pkg::OP_LOAD_COUNT, ctms_pkg::OP_LOAD_PROB: begin
                        cmd.load_wr = stat.cell_ok;
                        state_next  = S_FIN;
                    end
                    ctms_pkg::OP_READ: begin
                        cmd.rd_en    = 1'b1;
                        cmd.rd_sel   = ctms_pkg::RD_CELL;
                        useread_next = 1'b1;
                        state_next   = S_FIN;
                    end
                    default: begin
                        if (!stat.move_ok) begin
                            code_next  = ctms_pkg::ST_CODE_SKIP;
                            state_next = S_FIN;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = ctms_pkg::RD_PAIR_A;
                            state_next = S_RDX;
                        end
                    end
                endcase
            end
            S_RDX: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = ctms_pkg::RD_PAIR_X;
                cmd.cap_a  = 1'b1;
                state_next = S_CAPX;
            end
            S_CAPX: begin
                cmd.cap_x  = 1'b1;
                state_next = S_ZCHK;
            end
            S_ZCHK: begin
                k_next    = 2'd0;
                side_next = ctms_pkg::SIDE_NUM;
                if (stat.zero) begin
                    code_next  = ctms_pkg::ST_CODE_SKIP;
                    state_next = S_FIN;
                end else begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.mul_load = 1'b1;
                bit_next     = '0;
                state_next   = S_MUL;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                bit_next     = bit_reg + BW'(1);
                if (bit_reg == BW'(MW - 1)) begin
                    if (k_reg != 2'd3) begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_LOAD;
                    end else if (side_reg == ctms_pkg::SIDE_NUM) begin
                        state_next = S_SAVE;
                    end else begin
                        state_next = S_CMP;
                    end
                end
            end
            S_SAVE: begin
                cmd.save_num = 1'b1;
                k_next       = 2'd0;
                side_next    = ctms_pkg::SIDE_DEN;
                state_next   = S_LOAD;
            end
            S_CMP: begin
                widx_next = 2'd0;
                if (!stat.less || stat.full) begin
                    code_next  = ctms_pkg::ST_CODE_REJ;
                    state_next = S_FIN;
                end else begin
                    code_next = ctms_pkg::ST_CODE_ACC;
                    // With a shared group or candidate the four updates cancel out.
                    state_next = stat.alias_cells ? S_FIN : S_WR;
                end
            end
            S_WR: begin
                cmd.upd_wr = 1'b1;
                widx_next  = widx_reg + 2'd1;
                if (widx_reg == 2'd3) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
        bit_reg     <= bit_next;
        k_reg       <= k_next;
        side_reg    <= side_next;
        widx_reg    <= widx_next;
        code_reg    <= code_next;
        useread_reg <= useread_next;
    end

    // A finished result waits while the output beat is still held.
    a_fin_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && !out_free) |=> (state_reg == S_FIN))
        else $error("result left FIN while output was busy");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("output register overwritten");
    a_bit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |-> (bit_reg < BW'(MW)))
        else $error("multiplier step count overran");
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_EXEC))
        else $error("accepted beat not decoded");

endmodule

>>> src/contingency_table_mcmc_swap_step_top.sv
// Top level of the contingency-table swap-move block: stream ports, controller and datapath.
// One item is taken at a time. An evaluated move forms the numerator and the denominator
// with the bit-serial shift-add multiplier, one multiplier bit per cycle (MW is the larger
// of COUNT_WIDTH+1 and 17). An accepted move then writes the four updated counts, unless
// both named cells share a group or a candidate; a rejected move writes no count. A move
// is skipped for an out-of-range cell or for a zero cell. A finished result waits while a
// previous result beat is still held at the output.
// The result register frees the input side: a new beat is taken while a result waits.
// Table entries hold garbage until loaded.
module contingency_table_mcmc_swap_step_top #(
    parameter int MAX_GROUPS     = 8,
    parameter int MAX_CANDIDATES = 8,
    parameter int COUNT_WIDTH    = 16,
    parameter int PROB_FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // row, col, value, group_a, cand_a, group_b, cand_b, uniform_draw, zero fill
    input  logic [55:0] s_tdata,
    // op
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_value
    output logic [15:0] m_tdata,
    // status
    output logic [1:0]  m_tuser
);
    localparam int MW = (COUNT_WIDTH + 1 > 17) ? COUNT_WIDTH + 1 : 17;
    localparam int PW = 2 * COUNT_WIDTH + 52;

    ctms_pkg::cmd_t  cmd;
    ctms_pkg::stat_t stat;

    ctms_ctrl #(
        .MW(MW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .cmd     (cmd),
        .stat    (stat)
    );

    ctms_datapath #(
        .MAX_GROUPS     (MAX_GROUPS),
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .COUNT_WIDTH    (COUNT_WIDTH),
        .PROB_FRAC_BITS (PROB_FRAC_BITS),
        .MW             (MW),
        .PW             (PW)
    ) u_dp (
        .aclk       (aclk),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tuser),
        .in_row     (s_tdata[2:0]),
        .in_col     (s_tdata[5:3]),
        .in_value   (s_tdata[22:6]),
        .in_ga      (s_tdata[25:23]),
        .in_ca      (s_tdata[28:26]),
        .in_gb      (s_tdata[31:29]),
        .in_cb      (s_tdata[34:32]),
        .in_draw    (s_tdata[50:35]),
        .out_status (m_tuser),
        .out_read   (m_tdata)
    );

endmodule
